@@ rtl/lcts_pkg.sv @@
// Shared types, widths and constants of the lane coefficient track smoother.
// Used by every module of the block but lcts_ram; depends on nothing else.
package lcts_pkg;

    // Default number of lanes held in the state memory.
    localparam int LANE_COUNT_DEF = 4;

    // Field widths.
    localparam int LANE_W   = 2;
    localparam int COEFF_W  = 32;
    localparam int RATIO_W  = 17;
    localparam int COUNT_W  = 8;
    localparam int FRAMES_W = 7;

    // Blend arithmetic: difference, product and rounding.
    localparam int DIFF_W      = COEFF_W + 1;
    localparam int PROD_W      = DIFF_W + RATIO_W + 1;
    localparam int ROUND_SHIFT = 16;
    localparam int ROUND_HALF  = 32768;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_STEADY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_EARLY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_FRAMES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT   = 2'd3;

    // Configuration reset values.
    localparam logic [RATIO_W-1:0]  MIX_STEADY_RST   = 17'd3277;
    localparam logic [RATIO_W-1:0]  MIX_EARLY_RST    = 17'd13107;
    localparam logic [FRAMES_W-1:0] EARLY_FRAMES_RST = 7'd10;
    localparam logic [FRAMES_W-1:0] LOST_LIMIT_RST   = 7'd40;

    // A ratio of exactly 1.0 in Q1.16.
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

    typedef logic signed [COEFF_W-1:0] coeff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [COUNT_W-1:0] count_t;

    // Limits of the streak counter.
    localparam count_t COUNT_MAX = count_t'(8'h7f);
    localparam count_t COUNT_MIN = count_t'(8'h80);

    // One request: a lane and its freshly fitted quadratic.
    typedef struct packed {
        logic [LANE_W-1:0] lane_index;
        coeff_t            fit_quad;
        coeff_t            fit_linear;
        coeff_t            fit_offset;
    } lcts_in_t;

    // One result: the lane's state after the update.
    typedef struct packed {
        logic [LANE_W-1:0] out_lane;
        coeff_t            smooth_quad;
        coeff_t            smooth_linear;
        coeff_t            smooth_offset;
        logic              tracked;
        logic              seen_now;
        count_t            hit_count;
    } lcts_out_t;

    // One entry of the lane state memory; coefficient 0 is the quadratic term.
    typedef struct packed {
        coeff_t [2:0] coeff;
        logic         tracked;
        count_t       count;
    } lcts_entry_t;

    localparam int ENTRY_W = $bits(lcts_entry_t);

    // Configuration register file.
    typedef struct packed {
        logic [RATIO_W-1:0]  mix_steady;
        logic [RATIO_W-1:0]  mix_early;
        logic [FRAMES_W-1:0] early_frames;
        logic [FRAMES_W-1:0] lost_limit;
    } lcts_cfg_t;

    // Hand-over from the multiply stage to the commit stage.
    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              in_range;
        logic              seen;
        coeff_t [2:0]      old;
        prod_t [2:0]       prod;
        logic              tracked;
        count_t            count;
    } lcts_stage_t;

endpackage

@@ rtl/lcts_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the lane state memory.
module lcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; a read at the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lcts_prep.sv @@
// First datapath stage: ratio selection, coefficient differences, products
// and the streak counter update. Depends on lcts_pkg.
module lcts_prep (
    input  lcts_pkg::lcts_in_t    item,
    input  logic                  in_range,
    input  lcts_pkg::lcts_entry_t old,
    input  lcts_pkg::lcts_cfg_t   cfg,
    output lcts_pkg::lcts_stage_t stage
);

    logic                                seen;
    lcts_pkg::coeff_t [2:0]              fit;
    logic [lcts_pkg::RATIO_W-1:0]        early_sat;
    logic [lcts_pkg::RATIO_W-1:0]        steady_sat;
    logic [lcts_pkg::RATIO_W-1:0]        ratio;
    logic signed [lcts_pkg::DIFF_W-1:0]  diff [3];
    lcts_pkg::prod_t [2:0]               prod;
    lcts_pkg::count_t                    cnt_new;
    logic signed [lcts_pkg::COUNT_W:0]   cnt_ext;
    logic signed [lcts_pkg::COUNT_W:0]   lim_neg;

    assign fit  = {item.fit_offset, item.fit_linear, item.fit_quad};
    assign seen = (item.fit_quad != '0) || (item.fit_linear != '0) || (item.fit_offset != '0);

    // Ratio registers above 1.0 are clipped to 1.0.
    assign early_sat  = (cfg.mix_early > lcts_pkg::RATIO_ONE) ? lcts_pkg::RATIO_ONE
                                                                 : cfg.mix_early;
    assign steady_sat = (cfg.mix_steady > lcts_pkg::RATIO_ONE) ? lcts_pkg::RATIO_ONE
                                                                   : cfg.mix_steady;

    // An untracked lane copies the fit; otherwise the count picks the ratio.
    always_comb
    begin
        if (!old.tracked)
        begin
            ratio = lcts_pkg::RATIO_ONE;
        end
        else if ($signed(old.count) < $signed({1'b0, cfg.early_frames}))
        begin
            ratio = early_sat;
        end
        else
        begin
            ratio = steady_sat;
        end
    end

    // Difference and product for each term, one multiplier per term.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = $signed({fit[k][lcts_pkg::COEFF_W-1], fit[k]})
                    - $signed({old.coeff[k][lcts_pkg::COEFF_W-1], old.coeff[k]});
            prod[k] = diff[k] * $signed({1'b0, ratio});
        end
    end

    // Streak counter: a change of direction restarts it at zero.
    always_comb
    begin
        if (seen)
        begin
            if (old.count < 0)
            begin
                cnt_new = '0;
            end
            else if (old.count != lcts_pkg::COUNT_MAX)
            begin
                cnt_new = old.count + lcts_pkg::count_t'(1);
            end
            else
            begin
                cnt_new = old.count;
            end
        end
        else
        begin
            if (old.count > 0)
            begin
                cnt_new = '0;
            end
            else if (old.count != lcts_pkg::COUNT_MIN)
            begin
                cnt_new = old.count - lcts_pkg::count_t'(1);
            end
            else
            begin
                cnt_new = old.count;
            end
        end
    end

    // A miss drops the lane once the count falls below the negated limit.
    assign cnt_ext = {cnt_new[lcts_pkg::COUNT_W-1], cnt_new};
    assign lim_neg = -$signed({2'b00, cfg.lost_limit});

    assign stage.lane     = item.lane_index;
    assign stage.in_range = in_range;
    assign stage.seen     = seen;
    assign stage.old      = old.coeff;
    assign stage.prod     = prod;
    assign stage.count    = cnt_new;
    assign stage.tracked  = seen ? 1'b1 : (old.tracked && !(cnt_ext < lim_neg));

endmodule

@@ rtl/lcts_commit.sv @@
// Second datapath stage: rounds each product to Q16.16, adds it to the kept
// term and forms the write-back entry and the result. Depends on lcts_pkg.
module lcts_commit (
    input  lcts_pkg::lcts_stage_t stage,
    output lcts_pkg::lcts_entry_t entry,
    output lcts_pkg::lcts_out_t   result
);

    lcts_pkg::prod_t        rounded [3];
    lcts_pkg::coeff_t [2:0] blended;

    // Round half up, then add the step to the old term; a miss keeps the term.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rounded[k] = stage.prod[k] + lcts_pkg::prod_t'(lcts_pkg::ROUND_HALF);
            blended[k] = stage.seen
                       ? stage.old[k] + rounded[k][lcts_pkg::ROUND_SHIFT +: lcts_pkg::COEFF_W]
                       : stage.old[k];
        end
    end

    assign entry.coeff   = blended;
    assign entry.tracked = stage.tracked;
    assign entry.count   = stage.count;

    // A lane outside the memory reports only its index and the detection flag.
    always_comb
    begin
        result.out_lane = stage.lane;
        result.seen_now = stage.seen;
        if (stage.in_range)
        begin
            result.smooth_quad   = blended[0];
            result.smooth_linear = blended[1];
            result.smooth_offset = blended[2];
            result.tracked       = stage.tracked;
            result.hit_count     = stage.count;
        end
        else
        begin
            result.smooth_quad   = '0;
            result.smooth_linear = '0;
            result.smooth_offset = '0;
            result.tracked       = 1'b0;
            result.hit_count     = '0;
        end
    end

endmodule

@@ rtl/lane_coeff_track_smoother.sv @@
// Top level of the lane coefficient track smoother: lane state memory,
// read-modify-write pipeline and configuration registers.
// Depends on lcts_pkg, lcts_ram, lcts_prep and lcts_commit.
//
// Usage:
//   fit_valid/fit_ready/fit_item carry one request: a lane index and its fitted
//   quadratic in Q16.16. trk_valid/trk_ready/trk_item return one result per
//   request, in order: the lane's smoothed terms, tracked flag and streak count.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four registers (steady
//   ratio, early ratio, early frame count, lost limit); cfg_ready is always high.
//   A request passes the memory read into the first stage register, the multiply
//   stage and the commit into the output register before its result is valid.
//   Throughput: one request per cycle while consecutive requests name different
//   lanes and the receiver does not stall. A request for a lane still in the
//   multiply stage, or in the commit stage and not leaving it, waits; thus
//   back-to-back requests for one lane wait on the read-modify-write loop.
//   Reset: configuration returns to its defaults and a flag per lane marks every
//   memory entry as cleared, so all lanes start untracked with zero terms; no
//   clearing pass is needed. When the receiver stalls, up to three requests
//   are held (two stages and the output register), then fit_ready falls.
module lane_coeff_track_smoother #(
    parameter int LANE_COUNT = lcts_pkg::LANE_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fit_valid,
    output logic                               fit_ready,
    input  lcts_pkg::lcts_in_t                 fit_item,
    output logic                               trk_valid,
    input  logic                               trk_ready,
    output lcts_pkg::lcts_out_t                trk_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lcts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcts_pkg::RATIO_W-1:0]       cfg_data
);

    localparam int ADDR_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int EXT_W  = ADDR_W + lcts_pkg::LANE_W;

    lcts_pkg::lcts_cfg_t   cfg_reg;
    logic                  p1_v_reg;
    lcts_pkg::lcts_in_t    p1_item_reg;
    logic                  p1_range_reg;
    logic                  p2_v_reg;
    lcts_pkg::lcts_stage_t p2_reg;
    lcts_pkg::lcts_stage_t p2_next;
    logic                  out_v_reg;
    lcts_pkg::lcts_out_t   out_reg;
    lcts_pkg::lcts_out_t   out_next;
    logic                  wb_v_reg;
    logic [ADDR_W-1:0]     wb_addr_reg;
    lcts_pkg::lcts_entry_t wb_entry_reg;
    logic [LANE_COUNT-1:0] written_reg;

    logic [EXT_W-1:0]      fit_ext;
    logic [EXT_W-1:0]      p1_ext;
    logic [EXT_W-1:0]      p2_ext;
    logic                  fit_range;
    logic [ADDR_W-1:0]     fit_addr;
    logic [ADDR_W-1:0]     p1_addr;
    logic [ADDR_W-1:0]     p2_addr;
    logic                  p2_go;
    logic                  p1_go;
    logic                  hazard;
    logic                  fit_acc;
    logic                  ram_we;
    logic [lcts_pkg::ENTRY_W-1:0] ram_rdata;
    lcts_pkg::lcts_entry_t entry_old;
    lcts_pkg::lcts_entry_t entry_new;

    // Lane index to memory address, and whether the lane exists.
    assign fit_ext   = {{ADDR_W{1'b0}}, fit_item.lane_index};
    assign p1_ext    = {{ADDR_W{1'b0}}, p1_item_reg.lane_index};
    assign p2_ext    = {{ADDR_W{1'b0}}, p2_reg.lane};
    assign fit_range = fit_ext < EXT_W'(LANE_COUNT);
    assign fit_addr  = fit_ext[ADDR_W-1:0];
    assign p1_addr   = p1_ext[ADDR_W-1:0];
    assign p2_addr   = p2_ext[ADDR_W-1:0];

    // Pipeline flow: each stage moves when the one after it has room.
    assign p2_go = p2_v_reg && (!out_v_reg || trk_ready);
    assign p1_go = p1_v_reg && (!p2_v_reg || p2_go);

    // Interlock: a lane being modified in flight is not read again until its
    // update reaches the memory or the write-back register.
    assign hazard = (p1_v_reg && (p1_item_reg.lane_index == fit_item.lane_index))
                  || (p2_v_reg && !p2_go && (p2_reg.lane == fit_item.lane_index));

    assign fit_ready = (!p1_v_reg || p1_go) && !hazard;
    assign fit_acc   = fit_valid && fit_ready;
    assign ram_we    = p2_go && p2_reg.in_range;
    assign cfg_ready = 1'b1;

    // Lane state memory.
    lcts_ram #(
        .WIDTH (lcts_pkg::ENTRY_W),
        .DEPTH (LANE_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p2_addr),
        .wdata (entry_new),
        .re    (fit_acc),
        .raddr (fit_addr),
        .rdata (ram_rdata)
    );

    // Old entry: the latest write wins, and a never-written lane reads as zero.
    always_comb
    begin
        if (wb_v_reg && (wb_addr_reg == p1_addr))
        begin
            entry_old = wb_entry_reg;
        end
        else if (written_reg[p1_addr])
        begin
            entry_old = lcts_pkg::lcts_entry_t'(ram_rdata);
        end
        else
        begin
            entry_old = '0;
        end
    end

    lcts_prep u_prep (
        .item     (p1_item_reg),
        .in_range (p1_range_reg),
        .old      (entry_old),
        .cfg      (cfg_reg),
        .stage    (p2_next)
    );

    lcts_commit u_commit (
        .stage  (p2_reg),
        .entry  (entry_new),
        .result (out_next)
    );

    // Control state: stage valids, write-back tracking, written flags, registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            wb_v_reg    <= 1'b0;
            written_reg <= '0;
            cfg_reg.mix_steady   <= lcts_pkg::MIX_STEADY_RST;
            cfg_reg.mix_early    <= lcts_pkg::MIX_EARLY_RST;
            cfg_reg.early_frames <= lcts_pkg::EARLY_FRAMES_RST;
            cfg_reg.lost_limit   <= lcts_pkg::LOST_LIMIT_RST;
        end
        else
        begin
            if (fit_acc)
            begin
                p1_v_reg <= 1'b1;
            end
            else if (p1_go)
            begin
                p1_v_reg <= 1'b0;
            end

            if (p1_go)
            begin
                p2_v_reg <= 1'b1;
            end
            else if (p2_go)
            begin
                p2_v_reg <= 1'b0;
            end

            if (p2_go)
            begin
                out_v_reg <= 1'b1;
            end
            else if (trk_ready)
            begin
                out_v_reg <= 1'b0;
            end

            if (ram_we)
            begin
                wb_v_reg             <= 1'b1;
                written_reg[p2_addr] <= 1'b1;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    lcts_pkg::CFG_MIX_STEADY:
                    begin
                        cfg_reg.mix_steady <= cfg_data;
                    end
                    lcts_pkg::CFG_MIX_EARLY:
                    begin
                        cfg_reg.mix_early <= cfg_data;
                    end
                    lcts_pkg::CFG_EARLY_FRAMES:
                    begin
                        cfg_reg.early_frames <= cfg_data[lcts_pkg::FRAMES_W-1:0];
                    end
                    lcts_pkg::CFG_LOST_LIMIT:
                    begin
                        cfg_reg.lost_limit <= cfg_data[lcts_pkg::FRAMES_W-1:0];
                    end
                    default:
                    begin
                        cfg_reg <= cfg_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (fit_acc)
        begin
            p1_item_reg  <= fit_item;
            p1_range_reg <= fit_range;
        end
        if (p1_go)
        begin
            p2_reg <= p2_next;
        end
        if (p2_go)
        begin
            out_reg <= out_next;
        end
        if (ram_we)
        begin
            wb_addr_reg  <= p2_addr;
            wb_entry_reg <= entry_new;
        end
    end

    assign trk_valid = out_v_reg;
    assign trk_item  = out_reg;

endmodule

@@ rtl/lcts_checker.sv @@
// Port-level checks for the lane coefficient track smoother, bound to the
// top level. Depends on lcts_pkg and lane_coeff_track_smoother.
module lcts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                trk_valid,
    input logic                trk_ready,
    input lcts_pkg::lcts_out_t trk_item
);

    // A stalled result stays offered and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid && !trk_ready |=> trk_valid && $stable(trk_item))
        else $error("result changed or dropped while stalled");

    // A detection never leaves a negative streak count.
    a_hit_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid && trk_item.seen_now |-> !trk_item.hit_count[7])
        else $error("negative count after a detection");

    // A miss never leaves a positive streak count.
    a_miss_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid && !trk_item.seen_now |-> trk_item.hit_count[7] || (trk_item.hit_count == '0))
        else $error("positive count after a miss");

    // Nothing is offered straight out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !trk_valid)
        else $error("result offered at reset release");

endmodule

bind lane_coeff_track_smoother lcts_checker u_lcts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .trk_valid (trk_valid),
    .trk_ready (trk_ready),
    .trk_item  (trk_item)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lane_coeff_track_smoother: random and directed lane fits,
// with a predictor of the smoothed terms, tracked flag and streak count.
// Depends on lcts_pkg and the RTL of the block; reads no files.

import lcts_pkg::*;

// Predicts the lane state after each request and checks the returned results in order.
class lane_track_board;
    lcts_out_t           awaited[$];
    coeff_t              kept[LANE_COUNT_DEF][3];
    bit                  on_track[LANE_COUNT_DEF];
    int                  streak[LANE_COUNT_DEF];
    logic [RATIO_W-1:0]  mix_steady;
    logic [RATIO_W-1:0]  mix_early;
    logic [FRAMES_W-1:0] early_frames;
    logic [FRAMES_W-1:0] lost_limit;
    int                  failures;
    int                  reported;
    int                  taken;

    function new();
        mix_steady   = MIX_STEADY_RST;
        mix_early    = MIX_EARLY_RST;
        early_frames = EARLY_FRAMES_RST;
        lost_limit   = LOST_LIMIT_RST;
        failures     = 0;
        reported     = 0;
        taken        = 0;
        for (int ln = 0; ln < LANE_COUNT_DEF; ln++)
        begin
            for (int k = 0; k < 3; k++)
                kept[ln][k] = '0;
            on_track[ln] = 1'b0;
            streak[ln]   = 0;
        end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] data);
        case (idx)
            CFG_MIX_STEADY:   mix_steady   = data;
            CFG_MIX_EARLY:    mix_early    = data;
            CFG_EARLY_FRAMES: early_frames = data[FRAMES_W-1:0];
            CFG_LOST_LIMIT:   lost_limit   = data[FRAMES_W-1:0];
            default:          ;
        endcase
    endfunction

    // Only the first ten failures are printed; the rest are just counted.
    function void report(string msg);
        failures++;
        if (reported < 10)
        begin
            reported++;
            $display("%s", msg);
        end
    endfunction

    // Moves a kept term toward the fit: old + round(ratio * (fit - old)), round half up.
    function coeff_t blend_toward(coeff_t old, coeff_t fit, logic [RATIO_W-1:0] ratio);
        longint diff;
        longint prod;
        diff = longint'(fit) - longint'(old);
        prod = diff * longint'(ratio);
        return coeff_t'(longint'(old) + ((prod + longint'(ROUND_HALF)) >>> ROUND_SHIFT));
    endfunction

    // Updates the lane state for one accepted request and queues the expected result.
    function void note_request(lcts_in_t req);
        lcts_out_t          want;
        int                 ln;
        bit                 seen;
        logic [RATIO_W-1:0] ratio;
        coeff_t             fit[3];
        ln     = req.lane_index;
        fit[0] = req.fit_quad;
        fit[1] = req.fit_linear;
        fit[2] = req.fit_offset;
        seen   = (fit[0] != 0) || (fit[1] != 0) || (fit[2] != 0);
        if (seen)
        begin
            // The ratio is picked from the streak as it stood before this request.
            if (!on_track[ln])
                ratio = RATIO_ONE;
            else if (streak[ln] < int'(early_frames))
                ratio = (mix_early > RATIO_ONE) ? RATIO_ONE : mix_early;
            else
                ratio = (mix_steady > RATIO_ONE) ? RATIO_ONE : mix_steady;
            for (int k = 0; k < 3; k++)
                kept[ln][k] = blend_toward(kept[ln][k], fit[k], ratio);
            if (streak[ln] < 0)
                streak[ln] = 0;
            else if (streak[ln] < int'(COUNT_MAX))
                streak[ln]++;
            on_track[ln] = 1'b1;
        end
        else
        begin
            if (streak[ln] > 0)
                streak[ln] = 0;
            else if (streak[ln] > int'(COUNT_MIN))
                streak[ln]--;
            if (streak[ln] < -int'(lost_limit))
                on_track[ln] = 1'b0;
        end
        want.out_lane      = req.lane_index;
        want.smooth_quad   = kept[ln][0];
        want.smooth_linear = kept[ln][1];
        want.smooth_offset = kept[ln][2];
        want.tracked       = on_track[ln];
        want.seen_now      = seen;
        want.hit_count     = count_t'(streak[ln]);
        awaited = {awaited, want};
        taken++;
    endfunction

    function void check_result(lcts_out_t got);
        lcts_out_t want;
        bit        bad;
        if (awaited.size() == 0)
        begin
            report($sformatf("Unexpected result for lane %0d with nothing outstanding",
                             got.out_lane));
            return;
        end
        want = awaited.pop_front();
        bad  = (got.out_lane !== want.out_lane) || (got.smooth_quad !== want.smooth_quad) ||
               (got.smooth_linear !== want.smooth_linear) ||
               (got.smooth_offset !== want.smooth_offset) || (got.tracked !== want.tracked) ||
               (got.seen_now !== want.seen_now) || (got.hit_count !== want.hit_count);
        if (bad)
            report($sformatf({"Mismatch: expected lane %0d q %h l %h o %h trk %b seen %b cnt %0d",
                              ", got lane %0d q %h l %h o %h trk %b seen %b cnt %0d"},
                             want.out_lane, want.smooth_quad, want.smooth_linear,
                             want.smooth_offset, want.tracked, want.seen_now, want.hit_count,
                             got.out_lane, got.smooth_quad, got.smooth_linear,
                             got.smooth_offset, got.tracked, got.seen_now, got.hit_count));
    endfunction

    function void close_out();
        while (awaited.size() != 0)
        begin
            report($sformatf("Result for lane %0d never arrived", awaited[0].out_lane));
            void'(awaited.pop_front());
        end
    endfunction
endclass

module tb;

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  fit_valid = 1'b0;
    logic                  fit_ready;
    lcts_in_t              fit_item  = '0;
    logic                  trk_valid;
    logic                  trk_ready = 1'b0;
    lcts_out_t             trk_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIX_STEADY;
    logic [RATIO_W-1:0]    cfg_data  = '0;

    lane_track_board board = new();
    int unsigned     cycle_no   = 0;
    logic            rx_hold    = 1'b0;
    int              burst_left = 1;

    lane_coeff_track_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .fit_valid (fit_valid),
        .fit_ready (fit_ready),
        .fit_item  (fit_item),
        .trk_valid (trk_valid),
        .trk_ready (trk_ready),
        .trk_item  (trk_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // Result side: check each accepted result, then choose the next ready value.
    // The stall pattern cycles through free running, random stalls and a fixed rhythm.
    always @(posedge clk)
    begin
        if (rst_n && trk_valid && trk_ready)
            board.check_result(trk_item);
        case ((cycle_no / 700) % 3)
            0:       trk_ready <= !rx_hold;
            1:       trk_ready <= !rx_hold && ($urandom_range(0, 3) != 0);
            default: trk_ready <= !rx_hold && ((cycle_no % 9) >= 3);
        endcase
    end

    // One long hold-off on the result side, so that the pipeline fills and stalls requests.
    initial
    begin
        while (board.taken < 400)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog.
    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic lcts_in_t make_req(int lane, coeff_t q, coeff_t l, coeff_t o);
        lcts_in_t req;
        req.lane_index = LANE_W'(lane);
        req.fit_quad   = q;
        req.fit_linear = l;
        req.fit_offset = o;
        return req;
    endfunction

    // Coefficients drawn from full range, small values, extremes and mid range.
    function automatic coeff_t rand_coeff();
        case ($urandom_range(0, 5))
            0, 1:    return coeff_t'($urandom);
            2:       return coeff_t'(int'($urandom_range(0, 512)) - 256);
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000001;
                    3:       return 32'shffffffff;
                    default: return '0;
                endcase
            end
            default: return coeff_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic lcts_in_t hit_req(int lane);
        lcts_in_t req;
        req = make_req(lane, rand_coeff(), rand_coeff(), rand_coeff());
        if (req.fit_quad == 0 && req.fit_linear == 0 && req.fit_offset == 0)
            req.fit_offset = 32'sd1;
        return req;
    endfunction

    function automatic lcts_in_t miss_req(int lane);
        return make_req(lane, '0, '0, '0);
    endfunction

    // Offers one request and waits for it to be taken; bursts end in a random gap.
    task automatic send_fit(input lcts_in_t req);
        fit_item  <= req;
        fit_valid <= 1'b1;
        @(posedge clk);
        while (!fit_ready)
            @(posedge clk);
        board.note_request(req);
        burst_left--;
        if (burst_left <= 0)
        begin
            fit_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Waits until every outstanding result has come back and the pipeline is empty.
    task automatic drain();
        fit_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Registers change only once the block has gone idle.
    task automatic set_phase(input logic [RATIO_W-1:0] steady, input logic [RATIO_W-1:0] early,
                             input logic [RATIO_W-1:0] frames, input logic [RATIO_W-1:0] lost);
        drain();
        put_reg(CFG_MIX_STEADY, steady);
        put_reg(CFG_MIX_EARLY, early);
        put_reg(CFG_EARLY_FRAMES, frames);
        put_reg(CFG_LOST_LIMIT, lost);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic as runs of hits or misses on one lane, with single noisy requests
    // between them; the occasional long run drives the streak counter to its limits.
    task automatic run_random(input int count);
        int sent;
        int len;
        int lane;
        int kind;
        sent = 0;
        while (sent < count)
        begin
            lane = $urandom_range(0, LANE_COUNT_DEF - 1);
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 5) == 0) ? $urandom_range(120, 160) : $urandom_range(1, 12);
            if (kind >= 8)
                len = 1;
            if (len > count - sent)
                len = count - sent;
            repeat (len)
            begin
                if (kind < 5)
                    send_fit(hit_req(lane));
                else if (kind < 8)
                    send_fit(miss_req(lane));
                else if ($urandom_range(0, 3) == 0)
                    send_fit(miss_req($urandom_range(0, LANE_COUNT_DEF - 1)));
                else
                    send_fit(hit_req($urandom_range(0, LANE_COUNT_DEF - 1)));
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with reset defaults: miss on an untracked lane, a first hit that
        // copies extreme terms, blends, misses after hits, hits after misses, one term
        // nonzero at a time, and a run long enough to leave the early ratio behind.
        send_fit(miss_req(0));
        send_fit(make_req(0, 32'sh7fffffff, 32'sh80000000, 32'sh00000001));
        send_fit(make_req(0, 32'sh80000000, 32'sh7fffffff, 32'shffffffff));
        send_fit(miss_req(0));
        send_fit(miss_req(0));
        send_fit(make_req(0, 32'sh00000001, '0, '0));
        send_fit(make_req(1, '0, 32'sh00000001, '0));
        send_fit(make_req(2, '0, '0, 32'sh00000001));
        send_fit(make_req(3, 32'shffffffff, 32'shffffffff, 32'shffffffff));
        send_fit(make_req(3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_fit(make_req(2, 32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_fit(miss_req(1));
        repeat (10) send_fit(hit_req(3));
        run_random(250);

        // Extreme settings: no steady blending, full early blending, immediate loss.
        set_phase(17'd0, 17'd65536, 17'd0, 17'd0);
        run_random(250);

        // Long early phase and the longest tolerance of misses.
        set_phase(17'd65536, 17'd0, 17'd127, 17'd127);
        run_random(300);

        // Ratios above 1.0 are clamped.
        set_phase(17'h1ffff, 17'd100000, 17'd5, 17'd3);
        run_random(200);

        // Half ratio exposes the rounding of exact halves.
        set_phase(17'd1, 17'd32768, 17'd64, 17'd1);
        run_random(200);

        set_phase(RATIO_W'($urandom_range(0, 131071)), RATIO_W'($urandom_range(0, 131071)),
                  RATIO_W'($urandom_range(0, 131071)), RATIO_W'($urandom_range(0, 131071)));
        run_random(150);

        drain();
        repeat (6) @(posedge clk);
        board.close_out();
        if (board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
